// ===== hw/rtl/bcdp_pkg.sv =====
// Shared widths, register indexes and constants of the button counter and display.
`timescale 1ns / 1ps
`default_nettype none
package bcdp_pkg;

   localparam int ButtonsW = 8;
   localparam int CountW   = 17;
   localparam int PwmW     = 24;
   localparam int SegW     = 8;
   localparam int DigitW   = 4;
   localparam int CsrIdxW  = 4;
   localparam int CsrDataW = 17;

   // Configuration register indexes.
   localparam logic [CsrIdxW-1:0] CsrMaxValue     = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] CsrLedThreshold = CsrIdxW'(1);

   localparam logic [CountW-1:0] CountLimit        = CountW'(99999);
   localparam logic [CountW-1:0] MaxValueReset     = CountW'(100);
   localparam logic [CountW-1:0] LedThresholdReset = CountW'(95);

   // Watched buttons in handling order: bit position, direction and step size.
   localparam int NumBtn = 4;
   localparam int StepW  = 4;
   localparam logic [2:0]       BtnBit [NumBtn] = '{3'd0, 3'd5, 3'd6, 3'd7};
   localparam logic             BtnUp  [NumBtn] = '{1'b1, 1'b0, 1'b1, 1'b0};
   localparam logic [StepW-1:0] BtnStep[NumBtn] = '{4'd1, 4'd1, 4'd10, 4'd10};

   // Division by powers of ten as multiplication by a rounded-up reciprocal.
   // Each pair is exact for every count up to the five-digit limit.
   localparam int RecipW  = 18;
   localparam int ProdW   = CountW + RecipW;
   localparam logic [RecipW-1:0] Recip10    = RecipW'(209716);
   localparam int                Shift10    = 21;
   localparam logic [RecipW-1:0] Recip100   = RecipW'(167773);
   localparam int                Shift100   = 24;
   localparam logic [RecipW-1:0] Recip1000  = RecipW'(134218);
   localparam int                Shift1000  = 27;
   localparam logic [RecipW-1:0] Recip10000 = RecipW'(107375);
   localparam int                Shift10000 = 30;

   localparam logic [PwmW-1:0] PwmScale = PwmW'(100);

endpackage
`default_nettype wire

// ===== hw/rtl/bcdp_req_if.sv =====
// Button sample channel.
`timescale 1ns / 1ps
`default_nettype none
interface bcdp_req_if;
   import bcdp_pkg::*;

   logic                valid;
   logic                ready;
   logic [ButtonsW-1:0] buttons;

   modport source (output valid, output buttons, input ready);
   modport sink   (input valid, input buttons, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bcdp_rsp_if.sv =====
// Result channel: count, PWM compare value, indicator and segment codes.
`timescale 1ns / 1ps
`default_nettype none
interface bcdp_rsp_if;
   import bcdp_pkg::*;

   logic              valid;
   logic              ready;
   logic [CountW-1:0] count;
   logic [PwmW-1:0]   pwm_compare;
   logic              led_on;
   logic [SegW-1:0]   seg_units;
   logic [SegW-1:0]   seg_tens;
   logic [SegW-1:0]   seg_hundreds;
   logic [SegW-1:0]   seg_thousands;
   logic [SegW-1:0]   seg_ten_thousands;

   modport source (output valid, output count, output pwm_compare, output led_on,
                   output seg_units, output seg_tens, output seg_hundreds,
                   output seg_thousands, output seg_ten_thousands, input ready);
   modport sink   (input valid, input count, input pwm_compare, input led_on,
                   input seg_units, input seg_tens, input seg_hundreds,
                   input seg_thousands, input seg_ten_thousands, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bcdp_csr_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps
`default_nettype none
interface bcdp_csr_if;
   import bcdp_pkg::*;

   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bcdp_display.sv =====
// Two-stage decode of the count into PWM value, indicator and segment codes.
`timescale 1ns / 1ps
`default_nettype none
module bcdp_display (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [bcdp_pkg::CountW-1:0] in_count,
   input  wire logic [bcdp_pkg::CountW-1:0] led_threshold,
   bcdp_rsp_if.source                  rsp_ch
);
   import bcdp_pkg::*;

   function automatic logic [SegW-1:0] seg_code(input logic [DigitW-1:0] digit);
      logic [SegW-1:0] code;
      unique case (digit)
         4'd0:    code = 8'hAF;
         4'd1:    code = 8'hA0;
         4'd2:    code = 8'h6E;
         4'd3:    code = 8'hEA;
         4'd4:    code = 8'hE1;
         4'd5:    code = 8'hCB;
         4'd6:    code = 8'hCF;
         4'd7:    code = 8'hA2;
         4'd8:    code = 8'hEF;
         4'd9:    code = 8'hEB;
         default: code = '0;
      endcase
      return code;
   endfunction

   // Low nibble of ten times a value; the digit difference is known to be 0..9,
   // so only the low four bits matter.
   function automatic logic [DigitW-1:0] low_times10(input logic [DigitW-1:0] x);
      return {x[0], 3'b000} + {x[2:0], 1'b0};
   endfunction

   logic [ProdW-1:0] prod10, prod100, prod1000, prod10000;

   logic              s2_valid_ff;
   logic [CountW-1:0] s2_count_ff;
   logic [DigitW-1:0] q10_ff, q100_ff, q1000_ff, q10000_ff;
   logic [PwmW-1:0]   pwm_ff;
   logic              led_ff;
   logic              s2_ready;

   logic              out_valid_ff;
   logic [CountW-1:0] out_count_ff;
   logic [PwmW-1:0]   out_pwm_ff;
   logic              out_led_ff;
   logic [SegW-1:0]   seg_units_ff, seg_tens_ff, seg_hundreds_ff;
   logic [SegW-1:0]   seg_thousands_ff, seg_ten_thousands_ff;
   logic              out_ready;

   logic [DigitW-1:0] units_in, tens_in, hundreds_in, thousands_in;

   assign out_ready = !out_valid_ff || rsp_ch.ready;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign in_ready  = s2_ready;

   assign prod10    = ProdW'(in_count) * ProdW'(Recip10);
   assign prod100   = ProdW'(in_count) * ProdW'(Recip100);
   assign prod1000  = ProdW'(in_count) * ProdW'(Recip1000);
   assign prod10000 = ProdW'(in_count) * ProdW'(Recip10000);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && in_valid) begin
         s2_count_ff <= in_count;
         q10_ff      <= prod10[Shift10 +: DigitW];
         q100_ff     <= prod100[Shift100 +: DigitW];
         q1000_ff    <= prod1000[Shift1000 +: DigitW];
         q10000_ff   <= prod10000[Shift10000 +: DigitW];
         pwm_ff      <= PwmW'(in_count) * PwmScale;
         led_ff      <= (in_count > led_threshold);
      end
   end

   assign units_in     = s2_count_ff[DigitW-1:0] - low_times10(q10_ff);
   assign tens_in      = q10_ff - low_times10(q100_ff);
   assign hundreds_in  = q100_ff - low_times10(q1000_ff);
   assign thousands_in = q1000_ff - low_times10(q10000_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s2_valid_ff) begin
         out_count_ff         <= s2_count_ff;
         out_pwm_ff           <= pwm_ff;
         out_led_ff           <= led_ff;
         seg_units_ff         <= seg_code(units_in);
         seg_tens_ff          <= seg_code(tens_in);
         seg_hundreds_ff      <= seg_code(hundreds_in);
         seg_thousands_ff     <= seg_code(thousands_in);
         seg_ten_thousands_ff <= seg_code(q10000_ff);
      end
   end

   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.count             = out_count_ff;
   assign rsp_ch.pwm_compare       = out_pwm_ff;
   assign rsp_ch.led_on            = out_led_ff;
   assign rsp_ch.seg_units         = seg_units_ff;
   assign rsp_ch.seg_tens          = seg_tens_ff;
   assign rsp_ch.seg_hundreds      = seg_hundreds_ff;
   assign rsp_ch.seg_thousands     = seg_thousands_ff;
   assign rsp_ch.seg_ten_thousands = seg_ten_thousands_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/button_counter_display_pwm.sv =====
// Top level of the push-button up/down counter with PWM and segment decode.
//
// Each transfer on req_ch is one sample of an active-low button byte; bit 0
// adds 1, bit 5 subtracts 1, bit 6 adds 10 and bit 7 subtracts 10, each only
// on a new press, and the count is held within 0 and the smaller of max_value
// and 99999. Every sample gives exactly one result on rsp_ch. A new sample is
// taken in every cycle unless back-pressure from rsp_ch fills the pipeline: the
// press flags and the count are updated in the cycle of the transfer, and the
// decimal split, PWM product and segment lookup follow in two pipeline stages
// that stop taking work once full while a result waits. Registers are written
// through csr_ch (index 0 max_value, index 1 led_threshold, others ignored) only
// while the block is idle, a rule the user keeps; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module button_counter_display_pwm (
   input wire logic   clock,
   input wire logic   reset,
   bcdp_req_if.sink   req_ch,
   bcdp_rsp_if.source rsp_ch,
   bcdp_csr_if.sink   csr_ch
);
   import bcdp_pkg::*;

   // One button step: add or subtract, then clamp into 0..top.
   function automatic logic [CountW-1:0] count_step(
      input logic [CountW-1:0] cnt,
      input logic              up,
      input logic [StepW-1:0]  step,
      input logic [CountW-1:0] top
   );
      logic [CountW:0]   sum;
      logic [CountW-1:0] res;
      sum = {1'b0, cnt} + (CountW + 1)'(step);
      if (up) begin
         res = (sum > {1'b0, top}) ? top : sum[CountW-1:0];
      end else begin
         res = (cnt < CountW'(step)) ? '0 : cnt - CountW'(step);
         if (res > top) begin
            res = top;
         end
      end
      return res;
   endfunction

   logic [CountW-1:0] max_value_ff;
   logic [CountW-1:0] led_threshold_ff;
   logic [NumBtn-1:0] flags_ff, flags_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              s1_valid_ff;
   logic              s1_ready;
   logic              disp_ready;
   logic              accept;
   logic [CountW-1:0] top_clamp;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_value_ff     <= MaxValueReset;
         led_threshold_ff <= LedThresholdReset;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CsrMaxValue:     max_value_ff     <= CountW'(csr_ch.data);
            CsrLedThreshold: led_threshold_ff <= CountW'(csr_ch.data);
            default: ;
         endcase
      end
   end

   assign top_clamp = (max_value_ff > CountLimit) ? CountLimit : max_value_ff;

   // Buttons are handled in a fixed order, each seeing the count left by the last.
   always_comb begin
      logic [CountW-1:0] cnt;
      logic [NumBtn-1:0] flg;
      cnt = count_ff;
      flg = flags_ff;
      for (int i = 0; i < NumBtn; i++) begin
         if (!req_ch.buttons[BtnBit[i]]) begin
            if (!flg[i]) begin
               flg[i] = 1'b1;
               cnt    = count_step(cnt, BtnUp[i], BtnStep[i], top_clamp);
            end
         end else begin
            flg[i] = 1'b0;
         end
      end
      flags_in = flg;
      count_in = cnt;
   end

   assign s1_ready     = !s1_valid_ff || disp_ready;
   assign req_ch.ready = s1_ready;
   assign accept       = req_ch.valid && s1_ready;

   // The count register doubles as the first pipeline stage's payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff    <= '0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            flags_ff <= flags_in;
            count_ff <= count_in;
         end
         if (s1_ready) begin
            s1_valid_ff <= req_ch.valid;
         end
      end
   end

   bcdp_display u_display (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s1_valid_ff),
      .in_ready      (disp_ready),
      .in_count      (count_ff),
      .led_threshold (led_threshold_ff),
      .rsp_ch        (rsp_ch)
   );

endmodule
`default_nettype wire
